[sv/ipm_pkg.sv]
// Shared constants, codes and types of the isoparametric point mapper.
// Used by the channel interfaces and by every module of the block; no dependencies.
package ipm_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int REF_FRAC_BITS    = 16;
   localparam int REF_WIDTH        = REF_FRAC_BITS + 1;
   localparam int NUM_CORNERS      = 8;
   localparam int CORNER_IDX_WIDTH = $clog2(NUM_CORNERS);
   localparam int NUM_PAIRS        = 4;
   localparam int PAIR_IDX_WIDTH   = $clog2(NUM_PAIRS);
   localparam int NUM_AXES         = 3;
   localparam int AXIS_WIDTH       = 2;
   localparam int DIMS_WIDTH       = 2;
   localparam int ACTION_WIDTH     = 1;

   localparam int MUL_A_WIDTH = REF_WIDTH + 1;
   localparam int MUL_B_WIDTH = (COORD_WIDTH > REF_WIDTH) ? COORD_WIDTH : REF_WIDTH + 1;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + CORNER_IDX_WIDTH;
   localparam int SUM_WIDTH   = ACC_WIDTH - REF_FRAC_BITS;

   localparam int NUM_WEIGHT_STEPS = NUM_PAIRS + NUM_CORNERS;
   localparam int WSTEP_WIDTH      = $clog2(NUM_WEIGHT_STEPS);

   localparam logic [WSTEP_WIDTH-1:0] PAIR_LAST_STEP   = WSTEP_WIDTH'(NUM_PAIRS - 1);
   localparam logic [WSTEP_WIDTH-1:0] WEIGHT_LAST_STEP = WSTEP_WIDTH'(NUM_WEIGHT_STEPS - 1);

   localparam logic [REF_WIDTH-1:0] REF_ONE = {1'b1, {REF_FRAC_BITS{1'b0}}};

   localparam logic [ACTION_WIDTH-1:0] ACTION_LOAD = 1'b0;
   localparam logic [ACTION_WIDTH-1:0] ACTION_EVAL = 1'b1;

   localparam logic [DIMS_WIDTH-1:0] DIMS_NONE  = 2'd0;
   localparam logic [DIMS_WIDTH-1:0] DIMS_LINE  = 2'd1;
   localparam logic [DIMS_WIDTH-1:0] DIMS_QUAD  = 2'd2;
   localparam logic [DIMS_WIDTH-1:0] DIMS_HEX   = 2'd3;
   localparam logic [DIMS_WIDTH-1:0] DIMS_RESET = DIMS_HEX;

   localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

   typedef enum logic [1:0] {
      MAC_PAIR   = 2'd0,
      MAC_WEIGHT = 2'd1,
      MAC_BLEND  = 2'd2
   } mac_kind_type;

   typedef struct packed {
      logic                        issue;
      mac_kind_type                kind;
      logic [CORNER_IDX_WIDTH-1:0] slot;
      logic [AXIS_WIDTH-1:0]       axis;
      logic                        first;
      logic                        last;
   } mac_ctrl_type;

   typedef struct packed {
      logic                        valid;
      mac_kind_type                kind;
      logic [CORNER_IDX_WIDTH-1:0] slot;
      logic [REF_WIDTH-1:0]        value;
   } weight_wr_type;

   typedef struct packed {
      logic                          en;
      logic [CORNER_IDX_WIDTH-1:0]   index;
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } corner_wr_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } coord_triple_type;

endpackage

[sv/ipm_req_if.sv]
// Request channel of the point mapper: valid, ready and one request word.
// Depends on ipm_pkg for the field widths.
interface ipm_req_if;
   import ipm_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [ACTION_WIDTH-1:0]       action;
   logic [CORNER_IDX_WIDTH-1:0]   corner_index;
   logic signed [COORD_WIDTH-1:0] corner_x;
   logic signed [COORD_WIDTH-1:0] corner_y;
   logic signed [COORD_WIDTH-1:0] corner_z;
   logic [REF_WIDTH-1:0]          ref_u;
   logic [REF_WIDTH-1:0]          ref_v;
   logic [REF_WIDTH-1:0]          ref_w;

   modport source (
      output valid, action, corner_index, corner_x, corner_y, corner_z, ref_u, ref_v, ref_w,
      input  ready
   );

   modport sink (
      input  valid, action, corner_index, corner_x, corner_y, corner_z, ref_u, ref_v, ref_w,
      output ready
   );
endinterface

[sv/ipm_rsp_if.sv]
// Response channel of the point mapper: valid, ready and one mapped point word.
// Depends on ipm_pkg for the field widths.
interface ipm_rsp_if;
   import ipm_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;

   modport source (
      output valid, pos_x, pos_y, pos_z,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z,
      output ready
   );
endinterface

[sv/ipm_corner_store.sv]
// Corner vertex store: eight corners of x, y and z, cleared by reset.
// One write port for loads and one read port selected by axis and corner; uses ipm_pkg.
module ipm_corner_store (
   input  logic                            clock,
   input  logic                            reset,
   input  ipm_pkg::corner_wr_type          wr,
   input  logic [ipm_pkg::AXIS_WIDTH-1:0]  rd_axis,
   input  logic [ipm_pkg::CORNER_IDX_WIDTH-1:0] rd_index,
   output logic signed [ipm_pkg::COORD_WIDTH-1:0] rd_data
);
   import ipm_pkg::*;

   logic signed [COORD_WIDTH-1:0] x_ff [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] y_ff [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] z_ff [NUM_CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            x_ff[i] <= '0;
            y_ff[i] <= '0;
            z_ff[i] <= '0;
         end
      end else if (wr.en) begin
         x_ff[wr.index] <= wr.x;
         y_ff[wr.index] <= wr.y;
         z_ff[wr.index] <= wr.z;
      end
   end

   always_comb begin
      unique case (rd_axis)
         AXIS_X:  rd_data = x_ff[rd_index];
         AXIS_Y:  rd_data = y_ff[rd_index];
         AXIS_Z:  rd_data = z_ff[rd_index];
         default: rd_data = '0;
      endcase
   end
endmodule

[sv/ipm_mac_unit.sv]
// Shared multiply-accumulate unit: one registered multiplier that forms rounded
// weights and accumulates weighted corners with rounding and saturation. Uses ipm_pkg.
module ipm_mac_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ipm_pkg::mac_ctrl_type                    ctrl,
   input  logic signed [ipm_pkg::MUL_A_WIDTH-1:0]   op_a,
   input  logic signed [ipm_pkg::MUL_B_WIDTH-1:0]   op_b,
   output ipm_pkg::weight_wr_type                   weight_wr,
   output ipm_pkg::coord_triple_type                result
);
   import ipm_pkg::*;

   localparam logic signed [PROD_WIDTH-1:0] PROD_HALF = PROD_WIDTH'(1) << (REF_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0]  ACC_HALF  = ACC_WIDTH'(1) << (REF_FRAC_BITS - 1);
   localparam logic signed [SUM_WIDTH-1:0]  SUM_TOP =
      $signed({{(SUM_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
   localparam logic signed [SUM_WIDTH-1:0]  SUM_BOTTOM =
      $signed({{(SUM_WIDTH - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}});

   mac_ctrl_type                  tag_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic signed [PROD_WIDTH-1:0]  prod_in;
   logic signed [PROD_WIDTH-1:0]  prod_round;
   logic signed [ACC_WIDTH-1:0]   acc_ff;
   logic signed [ACC_WIDTH-1:0]   acc_in;
   logic signed [ACC_WIDTH-1:0]   acc_base;
   logic signed [SUM_WIDTH-1:0]   sum;
   logic signed [COORD_WIDTH-1:0] sat;
   coord_triple_type              result_ff;
   logic                          blend_valid;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_round = prod_ff + PROD_HALF;

   always_comb begin
      weight_wr.valid = tag_ff.issue && (tag_ff.kind != MAC_BLEND);
      weight_wr.kind  = tag_ff.kind;
      weight_wr.slot  = tag_ff.slot;
      weight_wr.value = prod_round[REF_FRAC_BITS +: REF_WIDTH];
   end

   assign blend_valid = tag_ff.issue && (tag_ff.kind == MAC_BLEND);
   assign acc_base    = tag_ff.first ? ACC_HALF : acc_ff;
   assign acc_in      = acc_base + ACC_WIDTH'(prod_ff);
   assign sum         = SUM_WIDTH'(acc_in >>> REF_FRAC_BITS);

   always_comb begin
      if (sum > SUM_TOP) begin
         sat = SUM_TOP[COORD_WIDTH-1:0];
      end else if (sum < SUM_BOTTOM) begin
         sat = SUM_BOTTOM[COORD_WIDTH-1:0];
      end else begin
         sat = sum[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (blend_valid) begin
         acc_ff <= acc_in;
         if (tag_ff.last) begin
            unique case (tag_ff.axis)
               AXIS_X:  result_ff.x <= sat;
               AXIS_Y:  result_ff.y <= sat;
               default: result_ff.z <= sat;
            endcase
         end
      end
   end

   assign result = result_ff;

   a_weight_in_range: assert property (@(posedge clock) disable iff (reset)
      weight_wr.valid |-> (weight_wr.value <= REF_ONE))
      else $error("rounded weight exceeds one");

   a_blend_first_follows_last: assert property (@(posedge clock) disable iff (reset)
      (blend_valid && tag_ff.last && ctrl.issue && (ctrl.kind == MAC_BLEND)) |-> ctrl.first)
      else $error("blend run started without first flag");

   a_tag_follows_ctrl: assert property (@(posedge clock) disable iff (reset)
      ctrl.issue |=> tag_ff.issue)
      else $error("issued operation lost in multiplier stage");
endmodule

[sv/ipm_sequencer.sv]
// Sequencer of the point mapper: accepts request words, holds the element
// dimension register, the reference point and the weights, drives the shared
// multiply-accumulate unit step by step and holds the response word. Uses ipm_pkg.
module ipm_sequencer (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_write_enable,
   input  logic [ipm_pkg::DIMS_WIDTH-1:0]              csr_write_data,
   ipm_req_if.sink                                     req_chan,
   ipm_rsp_if.source                                   rsp_chan,
   output ipm_pkg::corner_wr_type                      store_wr,
   output logic [ipm_pkg::AXIS_WIDTH-1:0]              rd_axis,
   output logic [ipm_pkg::CORNER_IDX_WIDTH-1:0]        rd_index,
   input  logic signed [ipm_pkg::COORD_WIDTH-1:0]      rd_data,
   output ipm_pkg::mac_ctrl_type                       mac_ctrl,
   output logic signed [ipm_pkg::MUL_A_WIDTH-1:0]      op_a,
   output logic signed [ipm_pkg::MUL_B_WIDTH-1:0]      op_b,
   input  ipm_pkg::weight_wr_type                      weight_wr,
   input  ipm_pkg::coord_triple_type                   mac_result
);
   import ipm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WEIGHT = 5'b00010,
      ST_BLEND  = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic [WSTEP_WIDTH-1:0]        step_ff, step_in;
   logic [CORNER_IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [AXIS_WIDTH-1:0]         axis_ff, axis_in;
   logic [DIMS_WIDTH-1:0]         csr_dims_ff;
   logic [DIMS_WIDTH-1:0]         dims_ff;
   logic [DIMS_WIDTH-1:0]         dims_sel;
   logic [REF_WIDTH-1:0]          u_ff, v_ff, w_ff, ua_ff, va_ff, wa_ff;
   logic [REF_WIDTH-1:0]          u_clamp, v_clamp, w_clamp;
   logic [REF_WIDTH-1:0]          pair_ff [NUM_PAIRS];
   logic [REF_WIDTH-1:0]          wt_ff [NUM_CORNERS];
   logic                          rsp_valid_ff;
   coord_triple_type              rsp_ff;
   logic                          req_accept;
   logic                          eval_accept;
   logic                          out_free;
   logic                          rsp_load;
   logic                          is_pair_step;
   logic [CORNER_IDX_WIDTH-1:0]   weight_index;
   logic [WSTEP_WIDTH-1:0]        last_step;
   logic [CORNER_IDX_WIDTH-1:0]   last_index;
   logic                          blend_last;
   logic                          axis_last;
   logic [REF_WIDTH-1:0]          mul_a_ref;
   logic [REF_WIDTH-1:0]          mul_b_ref;
   logic [REF_WIDTH-1:0]          blend_weight;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign eval_accept    = req_accept && (req_chan.action == ACTION_EVAL);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign dims_sel       = (csr_dims_ff == DIMS_NONE) ? DIMS_LINE : csr_dims_ff;

   assign u_clamp = (req_chan.ref_u > REF_ONE) ? REF_ONE : req_chan.ref_u;
   assign v_clamp = (req_chan.ref_v > REF_ONE) ? REF_ONE : req_chan.ref_v;
   assign w_clamp = (req_chan.ref_w > REF_ONE) ? REF_ONE : req_chan.ref_w;

   always_comb begin
      store_wr.en    = req_accept && (req_chan.action == ACTION_LOAD);
      store_wr.index = req_chan.corner_index;
      store_wr.x     = req_chan.corner_x;
      store_wr.y     = req_chan.corner_y;
      store_wr.z     = req_chan.corner_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_dims_ff <= DIMS_RESET;
      end else if (csr_write_enable) begin
         csr_dims_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_accept) begin
         dims_ff <= dims_sel;
         u_ff    <= u_clamp;
         v_ff    <= v_clamp;
         w_ff    <= w_clamp;
         ua_ff   <= REF_ONE - u_clamp;
         va_ff   <= REF_ONE - v_clamp;
         wa_ff   <= REF_ONE - w_clamp;
      end
      if (weight_wr.valid) begin
         if (weight_wr.kind == MAC_PAIR) begin
            pair_ff[weight_wr.slot[PAIR_IDX_WIDTH-1:0]] <= weight_wr.value;
         end else begin
            wt_ff[weight_wr.slot] <= weight_wr.value;
         end
      end
   end

   assign is_pair_step = (step_ff < WSTEP_WIDTH'(NUM_PAIRS));
   assign weight_index = CORNER_IDX_WIDTH'(step_ff - WSTEP_WIDTH'(NUM_PAIRS));
   assign last_step    = (dims_ff == DIMS_QUAD) ? PAIR_LAST_STEP : WEIGHT_LAST_STEP;
   assign axis_last    = (axis_ff == AXIS_WIDTH'(dims_ff - DIMS_WIDTH'(1)));

   always_comb begin
      unique case (dims_ff)
         DIMS_LINE: last_index = CORNER_IDX_WIDTH'(1);
         DIMS_QUAD: last_index = CORNER_IDX_WIDTH'(NUM_PAIRS - 1);
         default:   last_index = CORNER_IDX_WIDTH'(NUM_CORNERS - 1);
      endcase
   end

   assign blend_last = (idx_ff == last_index);

   always_comb begin
      unique case (dims_ff)
         DIMS_LINE: blend_weight = idx_ff[0] ? u_ff : ua_ff;
         DIMS_QUAD: blend_weight = pair_ff[idx_ff[PAIR_IDX_WIDTH-1:0]];
         default:   blend_weight = wt_ff[idx_ff];
      endcase
   end

   // Pair weights are (1-u)(1-v), u(1-v), uv, (1-u)v; corner weights scale
   // pair k by (1-w) for corners 0..3 and by w for corners 4..7.
   always_comb begin
      if (is_pair_step) begin
         mul_a_ref = (step_ff[0] ^ step_ff[1]) ? u_ff : ua_ff;
         mul_b_ref = step_ff[1] ? v_ff : va_ff;
      end else begin
         mul_a_ref = pair_ff[weight_index[PAIR_IDX_WIDTH-1:0]];
         mul_b_ref = weight_index[CORNER_IDX_WIDTH-1] ? w_ff : wa_ff;
      end
   end

   assign rd_axis  = axis_ff;
   assign rd_index = idx_ff;

   always_comb begin
      mac_ctrl = '0;
      op_a     = $signed({1'b0, mul_a_ref});
      op_b     = $signed({{(MUL_B_WIDTH - REF_WIDTH){1'b0}}, mul_b_ref});
      if (state_ff == ST_WEIGHT) begin
         mac_ctrl.issue = 1'b1;
         mac_ctrl.kind  = is_pair_step ? MAC_PAIR : MAC_WEIGHT;
         mac_ctrl.slot  = is_pair_step ? CORNER_IDX_WIDTH'(step_ff[PAIR_IDX_WIDTH-1:0])
                                       : weight_index;
      end else if (state_ff == ST_BLEND) begin
         mac_ctrl.issue = 1'b1;
         mac_ctrl.kind  = MAC_BLEND;
         mac_ctrl.slot  = idx_ff;
         mac_ctrl.axis  = axis_ff;
         mac_ctrl.first = (idx_ff == '0);
         mac_ctrl.last  = blend_last;
         op_a           = $signed({1'b0, blend_weight});
         op_b           = MUL_B_WIDTH'(rd_data);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      axis_in  = axis_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (eval_accept) begin
               step_in  = '0;
               idx_in   = '0;
               axis_in  = AXIS_X;
               state_in = (dims_sel == DIMS_LINE) ? ST_BLEND : ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            step_in = step_ff + WSTEP_WIDTH'(1);
            if (step_ff == last_step) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_last) begin
               idx_in = '0;
               if (axis_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  axis_in = axis_ff + AXIS_WIDTH'(1);
               end
            end else begin
               idx_in = idx_ff + CORNER_IDX_WIDTH'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.x <= mac_result.x;
         rsp_ff.y <= (dims_ff == DIMS_LINE) ? '0 : mac_result.y;
         rsp_ff.z <= (dims_ff == DIMS_HEX) ? mac_result.z : '0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pos_x = rsp_ff.x;
   assign rsp_chan.pos_y = rsp_ff.y;
   assign rsp_chan.pos_z = rsp_ff.z;

   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      eval_accept |=> (state_ff != ST_IDLE))
      else $error("evaluate word accepted but sequencer stayed idle");

   a_drain_after_last_blend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(mac_ctrl.issue && mac_ctrl.last && axis_last))
      else $error("drain entered without final accumulation");

   a_finish_loads_output: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished point not presented on the response channel");

   a_no_issue_when_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) || (state_ff == ST_FINISH)) |-> !mac_ctrl.issue)
      else $error("multiplier issued outside a compute state");
endmodule

[sv/isoparametric_point_mapper_unit.sv]
// Top level of the isoparametric point mapper; instantiates the corner store,
// the shared multiply-accumulate unit and the sequencer. Uses ipm_pkg and the channel interfaces.
//
// A load word writes one corner. An evaluate word maps (u, v, w) to a physical point
// with one shared 18 x 32 bit multiplier that first forms the rounded shape weights and
// then accumulates one weighted corner per cycle for each axis. An evaluate takes 12
// weight steps and 24 accumulate steps for a hexahedron, 4 and 8 for a quadrilateral
// and 2 accumulate steps for a line, then a drain state and an output state that waits
// until the previous response has been taken. The request channel is not ready until
// the evaluate is done.
// The element dimension register may be written only while the block is idle.
module isoparametric_point_mapper_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ipm_pkg::DIMS_WIDTH-1:0]  csr_write_data,
   ipm_req_if.sink                         req_chan,
   ipm_rsp_if.source                       rsp_chan
);
   import ipm_pkg::*;

   corner_wr_type                 store_wr;
   logic [AXIS_WIDTH-1:0]         rd_axis;
   logic [CORNER_IDX_WIDTH-1:0]   rd_index;
   logic signed [COORD_WIDTH-1:0] rd_data;
   mac_ctrl_type                  mac_ctrl;
   logic signed [MUL_A_WIDTH-1:0] op_a;
   logic signed [MUL_B_WIDTH-1:0] op_b;
   weight_wr_type                 weight_wr;
   coord_triple_type              mac_result;

   ipm_corner_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (store_wr),
      .rd_axis  (rd_axis),
      .rd_index (rd_index),
      .rd_data  (rd_data)
   );

   ipm_mac_unit u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .op_a      (op_a),
      .op_b      (op_b),
      .weight_wr (weight_wr),
      .result    (mac_result)
   );

   ipm_sequencer u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .store_wr         (store_wr),
      .rd_axis          (rd_axis),
      .rd_index         (rd_index),
      .rd_data          (rd_data),
      .mac_ctrl         (mac_ctrl),
      .op_a             (op_a),
      .op_b             (op_b),
      .weight_wr        (weight_wr),
      .mac_result       (mac_result)
   );
endmodule
